// File: sv/pidswi_pkg.sv
// ============================================================================
// pidswi_pkg
// Shared widths and register index codes of the windowed-integral PID core.
// ============================================================================
`timescale 1ns / 1ps

package pidswi_pkg;

    // Field widths of the payload and of the configuration registers.
    localparam int MEAS_W     = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 32;
    localparam int TERM_W     = 40;
    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI_DT      = 3'd1,
        CFG_KD_OVER_DT = 3'd2,
        CFG_OUT_MAX    = 3'd3,
        CFG_OUT_MIN    = 3'd4,
        CFG_SETPOINT   = 3'd5,
        CFG_WINDOW_LEN = 3'd6
    } t_cfg_idx;

endpackage

// File: sv/pid_sliding_window_integral_core.sv
// ============================================================================
// pid_sliding_window_integral_core
// Each sample passes stage registers one to four and then the output register.
// Throughput: one sample per cycle unless the result side stalls; the five-stage
// pipeline and the ring RAM (one read and one write each cycle) set that figure.
// Reset: registers take their defaults, the error window is empty; the ring
// RAM is not cleared, since only entries written since the last clear are used.
// ============================================================================
`timescale 1ns / 1ps

module pid_sliding_window_integral_core
    import pidswi_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int FRAC_BITS    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // Sample channel.
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [MEAS_W-1:0]  i_measured_value,
    // Result channel.
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [LIMIT_W-1:0] o_drive,
    output logic signed [TERM_W-1:0]  o_p_term,
    output logic signed [TERM_W-1:0]  o_i_term,
    output logic signed [TERM_W-1:0]  o_d_term
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SUM_W = ERR_W + AW;
    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int IP_W  = GAIN_W + SUM_W;
    localparam int DP_W  = GAIN_W + DIFF_W;
    localparam int ACC_W = (IP_W + 2 > TERM_W) ? IP_W + 2 : TERM_W;

    // Configuration registers.
    logic signed [GAIN_W-1:0]  r_kp;
    logic signed [GAIN_W-1:0]  r_ki_dt;
    logic signed [GAIN_W-1:0]  r_kd_over_dt;
    logic signed [LIMIT_W-1:0] r_out_max;
    logic signed [LIMIT_W-1:0] r_out_min;
    logic signed [MEAS_W-1:0]  r_setpoint;
    logic [LEN_W-1:0]          r_window_len;
    logic                      w_len_write;

    // Window state.
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [AW-1:0]             r_ptr;
    logic [AW-1:0]             n_ptr;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [ERR_W-1:0]   r_prev_err;

    // Pipeline stage registers.
    logic                      r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic signed [ERR_W-1:0]   r_s1_err;
    logic signed [DIFF_W-1:0]  r_s1_diff;
    logic                      r_s1_sub;
    logic                      r_s1_keep;
    logic signed [ERR_W-1:0]   r_s2_err;
    logic signed [DIFF_W-1:0]  r_s2_diff;
    logic signed [ACC_W-1:0]   r_s3_p, r_s3_i, r_s3_d;
    logic signed [ACC_W-1:0]   r_s4_sum;
    logic signed [TERM_W-1:0]  r_s4_p, r_s4_i, r_s4_d;
    logic signed [LIMIT_W-1:0] r_out_drive;
    logic signed [TERM_W-1:0]  r_out_p, r_out_i, r_out_d;

    // Handshake and stage movement.
    logic w_free_out, w_free4, w_free3, w_free2, w_free1;
    logic w_mv4, w_mv3, w_mv2, w_mv1, w_accept;

    // Front-end combinational signals.
    logic signed [ERR_W-1:0]   w_err;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [CNT_W-1:0]          w_len_eff;
    logic                      w_keep;
    logic                      w_full;
    logic [CNT_W-1:0]          w_dist;
    logic [AW-1:0]             w_old_addr;
    logic [ERR_W-1:0]          w_ram_rdata;
    logic signed [SUM_W-1:0]   w_old_ext;

    // Products and shifted terms.
    logic signed [PP_W-1:0]    w_p_prod;
    logic signed [IP_W-1:0]    w_i_prod;
    logic signed [DP_W-1:0]    w_d_prod;
    logic signed [ACC_W-1:0]   w_p_sh, w_i_sh, w_d_sh;

    // Configuration writes.
    assign w_len_write = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_WINDOW_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= GAIN_W'(256);
            r_ki_dt      <= '0;
            r_kd_over_dt <= '0;
            r_out_max    <= {1'b0, {(LIMIT_W-1){1'b1}}};
            r_out_min    <= {1'b1, {(LIMIT_W-1){1'b0}}};
            r_setpoint   <= '0;
            r_window_len <= LEN_W'(256);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:         r_kp         <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_DT:      r_ki_dt      <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_OVER_DT: r_kd_over_dt <= i_cfg_data[GAIN_W-1:0];
                CFG_OUT_MAX:    r_out_max    <= i_cfg_data[LIMIT_W-1:0];
                CFG_OUT_MIN:    r_out_min    <= i_cfg_data[LIMIT_W-1:0];
                CFG_SETPOINT:   r_setpoint   <= i_cfg_data[MEAS_W-1:0];
                CFG_WINDOW_LEN: r_window_len <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage movement: each stage advances when the next one is empty or leaving.
    assign w_free_out = !r_out_valid || !i_stall;
    assign w_free4    = !r_v4 || w_free_out;
    assign w_free3    = !r_v3 || w_free4;
    assign w_free2    = !r_v2 || w_free3;
    assign w_free1    = !r_v1 || w_free2;
    assign w_mv4      = r_v4 && w_free_out;
    assign w_mv3      = r_v3 && w_free4;
    assign w_mv2      = r_v2 && w_free3;
    assign w_mv1      = r_v1 && w_free2;
    assign w_accept   = i_valid && w_free1;
    assign o_stall    = !w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= w_accept || (r_v1 && !w_free2);
            r_v2        <= w_mv1 || (r_v2 && !w_free3);
            r_v3        <= w_mv2 || (r_v3 && !w_free4);
            r_v4        <= w_mv3 || (r_v4 && !w_free_out);
            r_out_valid <= w_mv4 || (r_out_valid && i_stall);
        end
    end

    // Error, derivative difference and the effective window length.
    assign w_err  = ERR_W'(r_setpoint) - ERR_W'(i_measured_value);
    assign w_diff = DIFF_W'(w_err) - DIFF_W'(r_prev_err);

    assign w_len_eff = (CMP_W'(r_window_len) > CMP_W'(WINDOW_DEPTH))
                       ? CNT_W'(WINDOW_DEPTH) : CNT_W'(r_window_len);
    assign w_keep    = (w_len_eff != '0);
    assign w_full    = (r_count >= w_len_eff);

    // Oldest entry of the window: pointer minus length, modulo the depth.
    always_comb begin
        w_dist = CNT_W'(WINDOW_DEPTH) - w_len_eff;
        if (CNT_W'(r_ptr) >= w_len_eff) begin
            w_old_addr = AW'(CNT_W'(r_ptr) - w_len_eff);
        end else begin
            w_old_addr = AW'(CNT_W'(r_ptr) + w_dist);
        end
    end

    // Next fill count and ring pointer for an accepted sample.
    always_comb begin
        n_count = r_count;
        n_ptr   = r_ptr;
        if (w_accept) begin
            if (!w_keep) begin
                n_count = '0;
            end else begin
                n_count = w_full ? w_len_eff : r_count + CNT_W'(1);
                n_ptr   = (r_ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
            end
        end
    end

    // Error ring: the new error is written while the oldest one is read.
    pidswi_ram #(
        .WIDTH (ERR_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_keep),
        .i_waddr (r_ptr),
        .i_wdata (w_err),
        .i_re    (w_accept),
        .i_raddr (w_old_addr),
        .o_rdata (w_ram_rdata)
    );

    // Running window sum, updated as a sample leaves stage one.
    assign w_old_ext = SUM_W'(signed'(w_ram_rdata));

    always_comb begin
        n_sum = r_sum;
        if (w_mv1) begin
            if (!r_s1_keep) begin
                n_sum = '0;
            end else if (r_s1_sub) begin
                n_sum = r_sum - w_old_ext + SUM_W'(r_s1_err);
            end else begin
                n_sum = r_sum + SUM_W'(r_s1_err);
            end
        end
    end

    // Window state registers; a window length write empties the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ptr      <= '0;
            r_sum      <= '0;
            r_prev_err <= '0;
        end else begin
            if (w_len_write) begin
                r_count <= '0;
                r_ptr   <= '0;
                r_sum   <= '0;
            end else begin
                r_count <= n_count;
                r_ptr   <= n_ptr;
                r_sum   <= n_sum;
            end
            if (w_accept) begin
                r_prev_err <= w_err;
            end
        end
    end

    // The three gain products; stage two sees the window sum of its own sample.
    assign w_p_prod = r_kp * r_s2_err;
    assign w_i_prod = r_ki_dt * r_sum;
    assign w_d_prod = r_kd_over_dt * r_s2_diff;
    assign w_p_sh   = ACC_W'(w_p_prod) >>> FRAC_BITS;
    assign w_i_sh   = ACC_W'(w_i_prod) >>> FRAC_BITS;
    assign w_d_sh   = ACC_W'(w_d_prod) >>> FRAC_BITS;

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_err  <= w_err;
            r_s1_diff <= w_diff;
            r_s1_sub  <= w_keep && w_full;
            r_s1_keep <= w_keep;
        end
        if (w_mv1) begin
            r_s2_err  <= r_s1_err;
            r_s2_diff <= r_s1_diff;
        end
        if (w_mv2) begin
            r_s3_p <= w_p_sh;
            r_s3_i <= w_i_sh;
            r_s3_d <= w_d_sh;
        end
        if (w_mv3) begin
            r_s4_sum <= r_s3_p + r_s3_i + r_s3_d;
            r_s4_p   <= r_s3_p[TERM_W-1:0];
            r_s4_i   <= r_s3_i[TERM_W-1:0];
            r_s4_d   <= r_s3_d[TERM_W-1:0];
        end
        if (w_mv4) begin
            // Upper limit is tested first; with crossed limits a sum above out_max gives out_max, any other out_min.
            if (r_s4_sum > ACC_W'(r_out_max)) begin
                r_out_drive <= r_out_max;
            end else if (r_s4_sum < ACC_W'(r_out_min)) begin
                r_out_drive <= r_out_min;
            end else begin
                r_out_drive <= r_s4_sum[LIMIT_W-1:0];
            end
            r_out_p <= r_s4_p;
            r_out_i <= r_s4_i;
            r_out_d <= r_s4_d;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_drive  = r_out_drive;
    assign o_p_term = r_out_p;
    assign o_i_term = r_out_i;
    assign o_d_term = r_out_d;

endmodule

// File: sv/pidswi_ram.sv
// ============================================================================
// pidswi_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. A read of the address being written returns the old contents.
// ============================================================================
`timescale 1ns / 1ps

module pidswi_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sim/pidswi_checker.sv
// ============================================================================
// pidswi_checker
// Watches the configuration port and both channels of the windowed-integral
// PID core, predicts every result transaction from the sample transactions
// and compares the results field by field in arrival order.
// ============================================================================
`timescale 1ns / 1ps

module pidswi_checker
    import pidswi_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int FRAC_BITS    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port, observed only.
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // Sample channel, observed only.
    input  logic                      i_sample_valid,
    input  logic                      i_sample_stall,
    input  logic signed [MEAS_W-1:0]  i_measured_value,
    // Result channel, observed only.
    input  logic                      i_result_valid,
    input  logic                      i_result_stall,
    input  logic signed [LIMIT_W-1:0] i_drive,
    input  logic signed [TERM_W-1:0]  i_p_term,
    input  logic signed [TERM_W-1:0]  i_i_term,
    input  logic signed [TERM_W-1:0]  i_d_term,
    // Status handed to the testbench top.
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [LIMIT_W-1:0] drive;
        logic [TERM_W-1:0]  p_term;
        logic [TERM_W-1:0]  i_term;
        logic [TERM_W-1:0]  d_term;
    } t_pid_outputs;

    // Shadow copy of the configuration registers.
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki_dt;
    logic signed [GAIN_W-1:0]  kd_over_dt;
    logic signed [LIMIT_W-1:0] out_max;
    logic signed [LIMIT_W-1:0] out_min;
    logic signed [MEAS_W-1:0]  setpoint;
    logic [LEN_W-1:0]          window_len;

    // Shadow copy of the error window and the derivative history.
    logic signed [ERR_W-1:0]   err_history [WINDOW_DEPTH];
    longint                    err_window_sum;
    int                        err_window_count;
    int                        write_slot;
    longint                    last_err;

    t_pid_outputs              expected_outputs [$];
    int                        fail_total;

    assign o_fail_count = fail_total;

    // Empties the error window; the derivative history is not touched.
    task automatic clear_window();
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            err_history[k] = '0;
        end
        err_window_sum   = 0;
        err_window_count = 0;
        write_slot       = 0;
    endtask

    // Advances the controller state by one sample and returns its outputs.
    function automatic t_pid_outputs predict_pid_outputs(input logic signed [MEAS_W-1:0] meas);
        longint       err;
        longint       p_val;
        longint       i_val;
        longint       d_val;
        longint       total;
        int           eff_len;
        int           oldest;
        t_pid_outputs res;

        err     = longint'(setpoint) - longint'(meas);
        eff_len = (int'(window_len) > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(window_len);

        // A zero-length window keeps nothing, so the integral stays at zero.
        if (eff_len == 0) begin
            err_window_sum   = 0;
            err_window_count = 0;
        end else begin
            if (err_window_count >= eff_len) begin
                oldest = (write_slot + WINDOW_DEPTH - eff_len) % WINDOW_DEPTH;
                err_window_sum   -= longint'(err_history[oldest]);
                err_window_count  = eff_len;
            end else begin
                err_window_count++;
            end
            err_window_sum         += err;
            err_history[write_slot] = err[ERR_W-1:0];
            write_slot              = (write_slot + 1) % WINDOW_DEPTH;
        end

        p_val    = (longint'(kp) * err) >>> FRAC_BITS;
        i_val    = (longint'(ki_dt) * err_window_sum) >>> FRAC_BITS;
        d_val    = (longint'(kd_over_dt) * (err - last_err)) >>> FRAC_BITS;
        last_err = err;

        // The upper limit is tested first; with crossed limits a total above out_max gives out_max, any other out_min.
        total = p_val + i_val + d_val;
        if (total > longint'(out_max)) begin
            res.drive = out_max;
        end else if (total < longint'(out_min)) begin
            res.drive = out_min;
        end else begin
            res.drive = total[LIMIT_W-1:0];
        end
        res.p_term = p_val[TERM_W-1:0];
        res.i_term = i_val[TERM_W-1:0];
        res.d_term = d_val[TERM_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Model update, prediction and comparison, all at the sampling edge.
    always @(posedge i_clk) begin
        t_pid_outputs want;

        if (!i_rst_n) begin
            kp         = 16'sd256;
            ki_dt      = '0;
            kd_over_dt = '0;
            out_max    = 32'sh7FFF_FFFF;
            out_min    = 32'sh8000_0000;
            setpoint   = '0;
            window_len = 9'd256;
            last_err   = 0;
            clear_window();
            expected_outputs.delete();
            fail_total = 0;
        end else begin
            // Register writes; an unknown index leaves everything as it was.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KP:         kp         = i_cfg_data[GAIN_W-1:0];
                    CFG_KI_DT:      ki_dt      = i_cfg_data[GAIN_W-1:0];
                    CFG_KD_OVER_DT: kd_over_dt = i_cfg_data[GAIN_W-1:0];
                    CFG_OUT_MAX:    out_max    = i_cfg_data[LIMIT_W-1:0];
                    CFG_OUT_MIN:    out_min    = i_cfg_data[LIMIT_W-1:0];
                    CFG_SETPOINT:   setpoint   = i_cfg_data[MEAS_W-1:0];
                    CFG_WINDOW_LEN: begin
                        window_len = i_cfg_data[LEN_W-1:0];
                        clear_window();
                    end
                    default: ;
                endcase
            end

            // Result transactions are matched before new samples are queued.
            if (i_result_valid && !i_result_stall) begin
                if (expected_outputs.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with nothing pending, expected none, actual drive %0d",
                             $time, i_drive);
                end else begin
                    want = expected_outputs.pop_front();
                    check_field("drive",  $signed(want.drive),  i_drive);
                    check_field("p_term", $signed(want.p_term), i_p_term);
                    check_field("i_term", $signed(want.i_term), i_i_term);
                    check_field("d_term", $signed(want.d_term), i_d_term);
                end
            end

            if (i_sample_valid && !i_sample_stall) begin
                expected_outputs.push_back(predict_pid_outputs(i_measured_value));
            end
        end
        o_pending <= expected_outputs.size();
    end

endmodule

// File: sim/pid_sliding_window_integral_core_tb.sv
// ============================================================================
// pid_sliding_window_integral_core_tb
// Drives sample transactions and register settings into the windowed-integral
// PID core under random back-pressure and reports the checker's verdict.
// ============================================================================
`timescale 1ns / 1ps

module pid_sliding_window_integral_core_tb;
    import pidswi_pkg::*;

    localparam int                   RANDOM_SHORT_ITEMS = 140;
    localparam int                   LONG_PHASE_ITEMS   = 260;
    localparam int                   DRAIN_CYCLES       = 8;
    localparam int                   TAIL_CYCLES        = 20;
    localparam int                   WATCHDOG_LIMIT     = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED     = 3'd7;

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data       = '0;
    logic                      i_valid          = 1'b0;
    logic signed [MEAS_W-1:0]  i_measured_value = '0;
    logic                      i_stall          = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [LIMIT_W-1:0] o_drive;
    logic signed [TERM_W-1:0]  o_p_term;
    logic signed [TERM_W-1:0]  o_i_term;
    logic signed [TERM_W-1:0]  o_d_term;

    int                        fail_count;
    int                        pending;
    int                        quiet_cycles     = 0;
    bit                        steady           = 1'b0;
    logic signed [MEAS_W-1:0]  cur_setpoint     = '0;
    int                        sent;

    pid_sliding_window_integral_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_measured_value (i_measured_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_drive          (o_drive),
        .o_p_term         (o_p_term),
        .o_i_term         (o_i_term),
        .o_d_term         (o_d_term)
    );

    pidswi_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_valid   (i_valid),
        .i_sample_stall   (o_stall),
        .i_measured_value (i_measured_value),
        .i_result_valid   (o_valid),
        .i_result_stall   (i_stall),
        .i_drive          (o_drive),
        .i_p_term         (o_p_term),
        .i_i_term         (o_i_term),
        .i_d_term         (o_d_term),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 i_clk = ~i_clk;

    // Ends the run if no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait drawn for each transaction; none at all during steady stretches.
    function automatic int draw_wait();
        if (steady) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Result side: stalls for a drawn time, then takes one result transaction.
    initial begin
        int n;
        bit got;

        @(posedge i_clk);
        forever begin
            n = draw_wait();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got = o_valid;
                @(posedge i_clk);
            end while (!got);
        end
    end

    // Holds one sample transaction until the core takes it.
    task automatic send_sample(input logic [MEAS_W-1:0] value);
        int  gap;
        bit  taken;

        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_measured_value <= value;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        sent++;
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes every register once the core has drained.
    task automatic configure(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] omax,
                             input logic [LIMIT_W-1:0] omin, input logic [MEAS_W-1:0] sp,
                             input logic [LEN_W-1:0] wlen);
        wait_idle();
        write_reg(CFG_KP,         {16'h0, kp});
        write_reg(CFG_KI_DT,      {16'h0, ki});
        write_reg(CFG_KD_OVER_DT, {16'h0, kd});
        write_reg(CFG_OUT_MAX,    omax);
        write_reg(CFG_OUT_MIN,    omin);
        write_reg(CFG_SETPOINT,   {16'h0, sp});
        write_reg(CFG_WINDOW_LEN, {23'h0, wlen});
        i_cfg_we     <= 1'b0;
        cur_setpoint  = sp;
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 1024)) - 16'd512;
            default: return 16'($urandom());
        endcase
    endfunction

    // Values near the setpoint, extremes and, most often, full-range noise.
    function automatic logic [MEAS_W-1:0] rand_meas();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return cur_setpoint + 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom());
        endcase
    endfunction

    // Picks a random setting for a phase of random samples.
    task automatic random_settings(input bit long_window);
        logic [LIMIT_W-1:0] omax;
        logic [LIMIT_W-1:0] omin;
        logic [LEN_W-1:0]   wlen;

        case ($urandom_range(0, 3))
            0: begin
                omax = 32'h7FFF_FFFF;
                omin = 32'h8000_0000;
            end
            1: begin
                omax = $urandom_range(0, 100000);
                omin = -$urandom_range(0, 100000);
            end
            2: begin
                omax = -$urandom_range(0, 1000);
                omin = $urandom_range(1, 1000);
            end
            default: begin
                omax = $urandom();
                omin = $urandom();
            end
        endcase
        if (long_window) begin
            wlen = LEN_W'($urandom_range(200, 511));
        end else begin
            case ($urandom_range(0, 7))
                0:       wlen = '0;
                1:       wlen = LEN_W'($urandom_range(17, 511));
                default: wlen = LEN_W'($urandom_range(1, 16));
            endcase
        end
        configure(rand_gain(), rand_gain(), rand_gain(), omax, omin, 16'($urandom()), wlen);
    endtask

    initial begin
        int n;

        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: unit proportional gain and a full-depth window.
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);

        // Largest positive gains and error, a window that wraps after three.
        configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 9'd3);
        repeat (4) send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);

        // Most negative gains and error with a window of one.
        configure(16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 9'd1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);

        // Zero-length window keeps the integral at zero; narrow limits clamp.
        configure(16'd256, 16'd256, 16'd256, 32'd100, -32'sd100, 16'h0000, 9'd0);
        send_sample(16'd50);
        send_sample(-16'sd50);
        send_sample(16'h0000);
        send_sample(16'h7FFF);

        // Crossed limits, and a window longer than the ring saturates.
        configure(16'd256, 16'd512, 16'd128, -32'sd10, 32'd10, 16'h0000, 9'd300);
        send_sample(16'h0000);
        send_sample(-16'sd5);
        send_sample(16'd20);
        send_sample(16'd5);

        // A write to an unknown index must change nothing.
        wait_idle();
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_sample(16'd3);

        // Random phases with mostly short windows, then one long phase that wraps the ring.
        sent = 0;
        while (sent < RANDOM_SHORT_ITEMS) begin
            random_settings(1'b0);
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 60);
            repeat (n) send_sample(rand_meas());
        end
        random_settings(1'b1);
        steady = 1'b0;
        for (int k = 0; k < LONG_PHASE_ITEMS; k++) begin
            if (k % 64 == 32) begin
                steady = ~steady;
            end
            send_sample(rand_meas());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/pidswi_pkg.sv
sv/pidswi_ram.sv
sv/pid_sliding_window_integral_core.sv
sim/pidswi_checker.sv
sim/pid_sliding_window_integral_core_tb.sv
